// ===== hw/rtl/ole_pkg.sv =====
`default_nettype none

package ole_pkg;

    // Widest list the engine is built for, and the index width that covers it.
    localparam int MAX_CAPACITY = 64;
    localparam int IDX_W = 7;
    localparam int DEFAULT_CAPACITY = 16;

    // At most this many results come out of one emit-all transaction.
    localparam int MAX_RESULTS = 16;

    // Operation codes.
    localparam logic [2:0] OP_APPEND = 3'd0;
    localparam logic [2:0] OP_INSERT = 3'd1;
    localparam logic [2:0] OP_FIND = 3'd2;
    localparam logic [2:0] OP_REMOVE_VAL = 3'd3;
    localparam logic [2:0] OP_REMOVE_AT = 3'd4;
    localparam logic [2:0] OP_EMIT = 3'd5;

    // Status codes.
    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_MISS = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;
    localparam logic [1:0] ST_EMPTY = 2'd3;

    typedef struct packed {
        logic [2:0] opcode;
        logic [3:0] position;
        logic signed [31:0] operand_value;
    } t_in;

    typedef struct packed {
        logic [1:0] status;
        logic [3:0] found_position;
        logic signed [31:0] item_value;
        logic [4:0] element_count;
        logic last;
    } t_out;

    // What every cell does in a cycle.
    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_APPEND,
        CELL_INSERT,
        CELL_DROP,
        CELL_ROTATE
    } t_cell_mode;

    // Control broadcast to the whole chain.
    typedef struct packed {
        t_cell_mode mode;
        logic [IDX_W-1:0] target;
        logic [IDX_W-1:0] last_idx;
        logic signed [31:0] operand;
        logic signed [31:0] head;
    } t_cell_ctl;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_EMIT
    } t_state;

endpackage

`default_nettype wire

// ===== hw/rtl/ole_cell.sv =====
`default_nettype none

module ole_cell #(
    parameter int IDX = 0
) (
    input  wire                     i_clk,
    input  wire ole_pkg::t_cell_ctl i_ctl,
    input  wire                     i_drop,
    input  wire logic signed [31:0] i_left,
    input  wire logic signed [31:0] i_right,
    output logic signed [31:0]      o_value,
    output logic                    o_match
);

    localparam logic [ole_pkg::IDX_W-1:0] MY_IDX = ole_pkg::IDX_W'(IDX);

    logic signed [31:0] r_value;

    // Element update: load, shift from a neighbor, or wrap the head around.
    always_ff @(posedge i_clk) begin
        unique case (i_ctl.mode)
            ole_pkg::CELL_HOLD: begin
                r_value <= r_value;
            end
            ole_pkg::CELL_APPEND: begin
                if (MY_IDX == i_ctl.target) begin
                    r_value <= i_ctl.operand;
                end
            end
            ole_pkg::CELL_INSERT: begin
                if (MY_IDX == i_ctl.target) begin
                    r_value <= i_ctl.operand;
                end else if (MY_IDX > i_ctl.target) begin
                    r_value <= i_left;
                end
            end
            ole_pkg::CELL_DROP: begin
                if (i_drop) begin
                    r_value <= i_right;
                end
            end
            ole_pkg::CELL_ROTATE: begin
                if (MY_IDX == i_ctl.last_idx) begin
                    r_value <= i_ctl.head;
                end else begin
                    r_value <= i_right;
                end
            end
        endcase
    end

    // Local compare against the broadcast operand.
    assign o_value = r_value;
    assign o_match = (r_value == i_ctl.operand);

endmodule

`default_nettype wire

// ===== hw/rtl/ordered_list_engine.sv =====
`default_nettype none

// Ordered list of up to CAPACITY signed 32-bit values, held in a chain of cells
// (cell k holds list position k). For append, insert, find, remove-by-value
// and remove-at, the idle state accepts the transaction and compares the
// operand in every cell at once, and the execute state shifts the chain and
// registers the single result. In emit all the chain rotates one place per
// cycle unless a stalled result blocks the next delivery; cell 0 supplies the
// next value, so after count rotations the list is back in order; only the
// first 16 values are delivered. A new transaction is taken while the previous
// result still waits in the output register.
module ordered_list_engine #(
    parameter int CAPACITY = ole_pkg::DEFAULT_CAPACITY
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_in_valid,
    input  wire ole_pkg::t_in i_in_data,
    output logic              o_in_stall,
    output logic              o_out_valid,
    output ole_pkg::t_out     o_out_data,
    input  wire               i_out_stall
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = $clog2(CAPACITY);
    localparam int XW = ole_pkg::IDX_W;
    localparam logic [XW-1:0] CAP_X = XW'(CAPACITY);
    localparam logic [XW-1:0] MAXR_X = XW'(ole_pkg::MAX_RESULTS);

    ole_pkg::t_state r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_idx, n_idx;
    ole_pkg::t_in r_cmd;
    logic [CAPACITY-1:0] r_match;
    logic r_out_valid;
    ole_pkg::t_out r_out;

    ole_pkg::t_cell_ctl w_ctl;
    logic [CAPACITY-1:0] w_drop;
    logic [CAPACITY-1:0] w_cell_match;
    logic [CAPACITY-1:0] w_live;
    logic signed [31:0] w_val [CAPACITY];

    logic in_accept, out_free, out_load;
    ole_pkg::t_out w_out;

    logic [XW-1:0] w_cnt_x, w_idx_x, w_pos_x, w_ins_x;
    logic w_full, w_emitting, w_last_rot, w_emit_adv;
    logic [CAPACITY-1:0] w_neg, w_first, w_ge;
    logic [IW-1:0] w_where;
    logic [IW+3:0] w_where_x;
    logic [CW+4:0] w_cnt_out_x;

    // Chain of cells; neighbors hand their values along.
    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            logic signed [31:0] w_left, w_right;
            if (g == 0) begin : g_first
                assign w_left = w_ctl.operand;
            end else begin : g_mid_l
                assign w_left = w_val[g-1];
            end
            if (g == CAPACITY - 1) begin : g_last
                assign w_right = w_val[g];
            end else begin : g_mid_r
                assign w_right = w_val[g+1];
            end
            ole_cell #(
                .IDX(g)
            ) u_cell (
                .i_clk   (i_clk),
                .i_ctl   (w_ctl),
                .i_drop  (w_drop[g]),
                .i_left  (w_left),
                .i_right (w_right),
                .o_value (w_val[g]),
                .o_match (w_cell_match[g])
            );
        end
    endgenerate

    // Handshake and shared decode.
    assign in_accept = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != ole_pkg::S_IDLE);
    assign out_free = !r_out_valid || !i_out_stall;

    assign w_cnt_x = XW'(r_count);
    assign w_idx_x = XW'(r_idx);
    assign w_pos_x = XW'(r_cmd.position);
    assign w_ins_x = (w_pos_x > w_cnt_x) ? w_cnt_x : w_pos_x;
    assign w_full = (w_cnt_x >= CAP_X);
    assign w_emitting = (w_idx_x < MAXR_X);
    assign w_last_rot = ((w_idx_x + XW'(1)) == w_cnt_x);
    assign w_emit_adv = !w_emitting || out_free;

    // First match and everything at or above it, from the registered matches.
    assign w_neg = (~r_match) + {{(CAPACITY-1){1'b0}}, 1'b1};
    assign w_first = r_match & w_neg;
    assign w_ge = r_match | w_neg;

    always_comb begin
        w_live = '0;
        w_where = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            w_live[i] = (XW'(i) < w_cnt_x);
            if (w_first[i]) begin
                w_where = w_where | IW'(i);
            end
        end
    end

    assign w_where_x = {4'b0000, w_where};

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ole_pkg::S_IDLE: begin
                if (in_accept) begin
                    n_state = ole_pkg::S_EXEC;
                end
            end
            ole_pkg::S_EXEC: begin
                if (out_free) begin
                    if (r_cmd.opcode == ole_pkg::OP_EMIT && r_count != '0) begin
                        n_state = ole_pkg::S_EMIT;
                    end else begin
                        n_state = ole_pkg::S_IDLE;
                    end
                end
            end
            ole_pkg::S_EMIT: begin
                if (w_emit_adv && w_last_rot) begin
                    n_state = ole_pkg::S_IDLE;
                end
            end
        endcase
    end

    // Cell control, count update and result formation.
    always_comb begin
        w_ctl.mode = ole_pkg::CELL_HOLD;
        w_ctl.target = '0;
        w_ctl.last_idx = w_cnt_x - XW'(1);
        w_ctl.operand = (r_state == ole_pkg::S_IDLE) ? i_in_data.operand_value
                                                      : r_cmd.operand_value;
        w_ctl.head = w_val[0];
        w_drop = '0;
        n_count = r_count;
        n_idx = r_idx;
        out_load = 1'b0;
        w_out.status = ole_pkg::ST_MISS;
        w_out.found_position = '0;
        w_out.item_value = '0;
        w_out.last = 1'b1;
        unique case (r_state)
            ole_pkg::S_IDLE: begin
            end
            ole_pkg::S_EXEC: begin
                if (out_free) begin
                    out_load = 1'b1;
                    unique case (r_cmd.opcode)
                        ole_pkg::OP_APPEND: begin
                            if (w_full) begin
                                w_out.status = ole_pkg::ST_FULL;
                            end else begin
                                w_ctl.mode = ole_pkg::CELL_APPEND;
                                w_ctl.target = w_cnt_x;
                                n_count = r_count + CW'(1);
                                w_out.status = ole_pkg::ST_OK;
                            end
                        end
                        ole_pkg::OP_INSERT: begin
                            if (w_full) begin
                                w_out.status = ole_pkg::ST_FULL;
                            end else begin
                                w_ctl.mode = ole_pkg::CELL_INSERT;
                                w_ctl.target = w_ins_x;
                                n_count = r_count + CW'(1);
                                w_out.status = ole_pkg::ST_OK;
                            end
                        end
                        ole_pkg::OP_FIND: begin
                            if (r_match != '0) begin
                                w_out.status = ole_pkg::ST_OK;
                                w_out.found_position = w_where_x[3:0];
                            end
                        end
                        ole_pkg::OP_REMOVE_VAL: begin
                            if (r_count == '0) begin
                                w_out.status = ole_pkg::ST_EMPTY;
                            end else if (r_match != '0) begin
                                w_ctl.mode = ole_pkg::CELL_DROP;
                                w_drop = w_ge;
                                n_count = r_count - CW'(1);
                                w_out.status = ole_pkg::ST_OK;
                            end
                        end
                        ole_pkg::OP_REMOVE_AT: begin
                            if (r_count == '0) begin
                                w_out.status = ole_pkg::ST_EMPTY;
                            end else if (w_pos_x < w_cnt_x) begin
                                w_ctl.mode = ole_pkg::CELL_DROP;
                                for (int i = 0; i < CAPACITY; i++) begin
                                    w_drop[i] = (XW'(i) >= w_pos_x);
                                end
                                n_count = r_count - CW'(1);
                                w_out.status = ole_pkg::ST_OK;
                            end
                        end
                        ole_pkg::OP_EMIT: begin
                            if (r_count == '0) begin
                                w_out.status = ole_pkg::ST_EMPTY;
                            end else begin
                                out_load = 1'b0;
                                n_idx = '0;
                            end
                        end
                        default: begin
                            w_out.status = ole_pkg::ST_MISS;
                        end
                    endcase
                end
            end
            ole_pkg::S_EMIT: begin
                if (w_emit_adv) begin
                    w_ctl.mode = ole_pkg::CELL_ROTATE;
                    n_idx = r_idx + CW'(1);
                    out_load = w_emitting;
                    w_out.status = ole_pkg::ST_OK;
                    w_out.item_value = w_val[0];
                    w_out.last = w_last_rot || ((w_idx_x + XW'(1)) == MAXR_X);
                end
            end
        endcase
        w_cnt_out_x = {5'b00000, n_count};
        w_out.element_count = w_cnt_out_x[4:0];
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ole_pkg::S_IDLE;
            r_count <= '0;
            r_idx <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_idx <= n_idx;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Transaction capture, match vector and result register.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_cmd <= i_in_data;
            r_match <= w_cell_match & w_live;
        end
        if (out_load) begin
            r_out <= w_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data = r_out;

`ifndef SYNTHESIS
    // The element count never passes the capacity.
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        XW'(r_count) <= CAP_X)
        else $error("element count exceeds capacity");

    // An accepted transaction always enters the execute state in the next cycle.
    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> (r_state == ole_pkg::S_EXEC))
        else $error("accepted transaction not executed");

    // A waiting result is never overwritten.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |=> (r_out_valid && $stable(r_out)))
        else $error("pending result overwritten");

    // Rotation index stays inside the list while emitting.
    a_emit_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ole_pkg::S_EMIT) |-> (w_idx_x < w_cnt_x))
        else $error("emit index out of range");
`endif

endmodule

`default_nettype wire
